FILE: design/afc_pkg.sv
// Shared types and constants for the box/frustum classifier.
// No dependencies; used by afc_mac and aabb_frustum_classify.
package afc_pkg;

   localparam int COORD_WIDTH  = 16;
   localparam int COEF_W       = 16;
   localparam int FRAC_BITS    = 14;
   localparam int PLANE_COUNT  = 6;
   localparam int AXIS_COUNT   = 3;
   localparam int PLANE_W      = 4 * COEF_W;
   localparam int PLANE_IDX_W  = $clog2(PLANE_COUNT);
   localparam int AXIS_IDX_W   = $clog2(AXIS_COUNT);
   localparam int PROD_W       = COEF_W + COORD_WIDTH;
   localparam int OFF_W        = COEF_W + FRAC_BITS;
   // three products plus the aligned offset, with headroom
   localparam int ACC_W        = ((PROD_W > OFF_W) ? PROD_W : OFF_W) + 2;
   localparam int VERDICT_W    = 2;

   localparam logic [VERDICT_W-1:0] VERDICT_OUTSIDE = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_PARTIAL = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_INSIDE  = 2'd2;

   localparam logic [PLANE_IDX_W-1:0] LAST_PLANE = PLANE_IDX_W'(PLANE_COUNT - 1);
   localparam logic [AXIS_IDX_W-1:0]  LAST_AXIS  = AXIS_IDX_W'(AXIS_COUNT - 1);

   // tag travelling with each product through the shared unit
   typedef struct packed {
      logic side;        // 0: lo corner, 1: hi corner
      logic axis_first;
      logic axis_last;
   } afc_step_type;

   // one plane's outcome
   typedef struct packed {
      logic valid;
      logic any_front;   // some corner strictly in front
      logic all_front;   // all eight corners strictly in front
   } afc_plane_res_type;

endpackage

FILE: design/afc_mac.sv
// Shared multiplier with min/max accumulation for one plane at a time.
// Depends on afc_pkg.
module afc_mac (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   step_valid,
   input  afc_pkg::afc_step_type                  step,
   input  logic signed [afc_pkg::COEF_W-1:0]      coef,
   input  logic signed [afc_pkg::COORD_WIDTH-1:0] coord,
   input  logic signed [afc_pkg::COEF_W-1:0]      offset,
   output afc_pkg::afc_plane_res_type             plane_res
);

   logic signed [afc_pkg::PROD_W-1:0] prod_in;
   logic signed [afc_pkg::PROD_W-1:0] prod_ff;
   logic                              p_vld_ff;
   afc_pkg::afc_step_type             p_step_ff;
   logic signed [afc_pkg::COEF_W-1:0] p_off_ff;

   logic signed [afc_pkg::PROD_W-1:0] lo_ff;
   logic signed [afc_pkg::ACC_W-1:0]  accmax_ff, accmax_in;
   logic signed [afc_pkg::ACC_W-1:0]  accmin_ff, accmin_in;

   logic signed [afc_pkg::PROD_W-1:0] big, sml;
   logic signed [afc_pkg::ACC_W-1:0]  off_ext, base_max, base_min;
   logic                              acc_step;

   assign prod_in = coef * coord;

   // stage 1: product
   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else begin
         p_vld_ff <= step_valid;
      end
      if (step_valid) begin
         prod_ff   <= prod_in;
         p_step_ff <= step;
         p_off_ff  <= offset;
      end
   end

   // stage 2: per axis take the larger and smaller corner term
   assign acc_step = p_vld_ff && p_step_ff.side;
   assign big      = (prod_ff > lo_ff) ? prod_ff : lo_ff;
   assign sml      = (prod_ff > lo_ff) ? lo_ff : prod_ff;
   assign off_ext  = afc_pkg::ACC_W'(p_off_ff) <<< afc_pkg::FRAC_BITS;
   assign base_max = p_step_ff.axis_first ? off_ext : accmax_ff;
   assign base_min = p_step_ff.axis_first ? off_ext : accmin_ff;
   assign accmax_in = base_max + afc_pkg::ACC_W'(big);
   assign accmin_in = base_min + afc_pkg::ACC_W'(sml);

   always_ff @(posedge clock) begin
      if (p_vld_ff && !p_step_ff.side) begin
         lo_ff <= prod_ff;
      end
      if (acc_step) begin
         accmax_ff <= accmax_in;
         accmin_ff <= accmin_in;
      end
   end

   // best corner decides "any in front", worst corner decides "all in front"
   always_comb begin
      plane_res.valid     = acc_step && p_step_ff.axis_last;
      plane_res.any_front = accmax_in > 0;
      plane_res.all_front = accmin_in > 0;
   end

endmodule

FILE: design/aabb_frustum_classify.sv
// Box versus six-plane frustum classifier, top level.
// Depends on afc_pkg and afc_mac.
// Boxes are taken one at a time: req_ready is high only in idle.
// Per box: 36 products on the shared multiplier (6 planes x 3 axes x lo/hi),
// a drain of the last products, a load of the response slot and a return to
// idle; a full response slot stalls the sequencer until it drains.
// Reset (synchronous, active high) clears the sequencer, the response slot
// and all six plane registers to zero, so every box then reads as outside.
module aabb_frustum_classify (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [afc_pkg::COORD_WIDTH-1:0] req_box_lo_x,
   input  logic signed [afc_pkg::COORD_WIDTH-1:0] req_box_lo_y,
   input  logic signed [afc_pkg::COORD_WIDTH-1:0] req_box_lo_z,
   input  logic signed [afc_pkg::COORD_WIDTH-1:0] req_box_hi_x,
   input  logic signed [afc_pkg::COORD_WIDTH-1:0] req_box_hi_y,
   input  logic signed [afc_pkg::COORD_WIDTH-1:0] req_box_hi_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [afc_pkg::VERDICT_W-1:0]          rsp_verdict,
   input  logic                                   csr_write,
   input  logic [afc_pkg::PLANE_IDX_W-1:0]        csr_index,
   input  logic [afc_pkg::PLANE_W-1:0]            csr_data
);

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MUL   = 2'd1;  // issuing products
   localparam logic [1:0] ST_DRAIN = 2'd2;  // last products in flight
   localparam logic [1:0] ST_DONE  = 2'd3;  // verdict ready, waiting for slot

   logic [1:0] state_ff, state_in;

   // plane registers: nx [15:0], ny [31:16], nz [47:32], offset [63:48]
   logic [afc_pkg::PLANE_W-1:0] plane_ff [afc_pkg::PLANE_COUNT];

   // captured box, indexed by axis
   logic signed [afc_pkg::COORD_WIDTH-1:0] lo_ff [afc_pkg::AXIS_COUNT];
   logic signed [afc_pkg::COORD_WIDTH-1:0] hi_ff [afc_pkg::AXIS_COUNT];

   logic [afc_pkg::PLANE_IDX_W-1:0] plane_idx_ff;
   logic [afc_pkg::AXIS_IDX_W-1:0]  axis_ff;
   logic                            side_ff;

   logic outside_ff;   // some plane has every corner behind or on it
   logic all_in_ff;    // every plane so far has all corners in front

   // marks that the last plane result has been folded into the flags
   logic drain_seen_ff;

   logic                          rsp_valid_ff;
   logic [afc_pkg::VERDICT_W-1:0] rsp_verdict_ff, verdict;

   logic                                   req_xfer, rsp_xfer, issue, last_issue;
   logic [afc_pkg::PLANE_W-1:0]            cur_plane;
   logic signed [afc_pkg::COEF_W-1:0]      coef, offset;
   logic signed [afc_pkg::COORD_WIDTH-1:0] coord;
   afc_pkg::afc_step_type                  step;
   afc_pkg::afc_plane_res_type             plane_res;
   logic                                   mac_busy;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = rsp_valid_ff && rsp_ready;

   // configuration writes; indexes past the last plane are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < afc_pkg::PLANE_COUNT; i++) begin
            plane_ff[i] <= '0;
         end
      end else if (csr_write && (csr_index <= afc_pkg::LAST_PLANE)) begin
         plane_ff[csr_index] <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         lo_ff[0] <= req_box_lo_x;
         lo_ff[1] <= req_box_lo_y;
         lo_ff[2] <= req_box_lo_z;
         hi_ff[0] <= req_box_hi_x;
         hi_ff[1] <= req_box_hi_y;
         hi_ff[2] <= req_box_hi_z;
      end
   end

   // operand selection for the shared unit
   assign issue      = (state_ff == ST_MUL);
   assign last_issue = issue && side_ff && (axis_ff == afc_pkg::LAST_AXIS)
                       && (plane_idx_ff == afc_pkg::LAST_PLANE);
   assign cur_plane  = plane_ff[plane_idx_ff];
   assign coef       = cur_plane[axis_ff * afc_pkg::COEF_W +: afc_pkg::COEF_W];
   assign offset     = cur_plane[afc_pkg::PLANE_W-1 -: afc_pkg::COEF_W];
   assign coord      = side_ff ? hi_ff[axis_ff] : lo_ff[axis_ff];

   always_comb begin
      step.side       = side_ff;
      step.axis_first = (axis_ff == '0);
      step.axis_last  = (axis_ff == afc_pkg::LAST_AXIS);
   end

   afc_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .step_valid (issue),
      .step       (step),
      .coef       (coef),
      .coord      (coord),
      .offset     (offset),
      .plane_res  (plane_res)
   );

   // the unit's product stage is empty once the accumulate stage has fired
   assign mac_busy = plane_res.valid;

   // step counters: side fastest, then axis, then plane
   always_ff @(posedge clock) begin
      if (reset) begin
         plane_idx_ff <= '0;
         axis_ff      <= '0;
         side_ff      <= 1'b0;
      end else if (req_xfer) begin
         plane_idx_ff <= '0;
         axis_ff      <= '0;
         side_ff      <= 1'b0;
      end else if (issue) begin
         side_ff <= !side_ff;
         if (side_ff) begin
            if (axis_ff == afc_pkg::LAST_AXIS) begin
               axis_ff      <= '0;
               plane_idx_ff <= plane_idx_ff + 1'b1;
            end else begin
               axis_ff <= axis_ff + 1'b1;
            end
         end
      end
   end

   // running verdict flags
   always_ff @(posedge clock) begin
      if (reset) begin
         outside_ff <= 1'b0;
         all_in_ff  <= 1'b1;
      end else if (req_xfer) begin
         outside_ff <= 1'b0;
         all_in_ff  <= 1'b1;
      end else if (plane_res.valid) begin
         outside_ff <= outside_ff || !plane_res.any_front;
         all_in_ff  <= all_in_ff && plane_res.all_front;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) state_in = ST_MUL;
         end
         ST_MUL: begin
            if (last_issue) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            // the final product is registered, then its plane result is folded into the flags
            if (!mac_busy && (state_ff == ST_DRAIN) && drain_seen_ff) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drain_seen_ff <= 1'b0;
      end else if (state_ff != ST_DRAIN) begin
         drain_seen_ff <= 1'b0;
      end else if (mac_busy) begin
         drain_seen_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      if (outside_ff) begin
         verdict = afc_pkg::VERDICT_OUTSIDE;
      end else if (all_in_ff) begin
         verdict = afc_pkg::VERDICT_INSIDE;
      end else begin
         verdict = afc_pkg::VERDICT_PARTIAL;
      end
   end

   // response slot; a waiting result does not block the next req transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_xfer) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready)) begin
         rsp_verdict_ff <= verdict;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Testbench for aabb_frustum_classify: directed and random boxes against several plane sets.
// Depends on afc_pkg and the classifier RTL; verdicts are predicted in a scoreboard class.
module testbench;

   localparam int COORD_WIDTH = afc_pkg::COORD_WIDTH;
   localparam int COEF_W      = afc_pkg::COEF_W;
   localparam int FRAC_BITS   = afc_pkg::FRAC_BITS;
   localparam int PLANE_COUNT = afc_pkg::PLANE_COUNT;
   localparam int PLANE_W     = afc_pkg::PLANE_W;
   localparam int PLANE_IDX_W = afc_pkg::PLANE_IDX_W;
   localparam int VERDICT_W   = afc_pkg::VERDICT_W;

   localparam logic [VERDICT_W-1:0] VERDICT_OUTSIDE = afc_pkg::VERDICT_OUTSIDE;
   localparam logic [VERDICT_W-1:0] VERDICT_PARTIAL = afc_pkg::VERDICT_PARTIAL;
   localparam logic [VERDICT_W-1:0] VERDICT_INSIDE  = afc_pkg::VERDICT_INSIDE;

   // register indexes of the six planes
   localparam int NEAR_IDX   = 0;
   localparam int FAR_IDX    = 1;
   localparam int LEFT_IDX   = 2;
   localparam int RIGHT_IDX  = 3;
   localparam int BOTTOM_IDX = 4;
   localparam int TOP_IDX    = 5;

   localparam int CORNER_COUNT    = 8;
   localparam int RANDOM_PHASES   = 10;
   localparam int BOXES_PER_PHASE = 170;
   localparam int LONG_HOLD       = 400;   // receiver hold-off, cycles
   localparam int DRAIN_CYCLES    = 80;    // idle wait before the final report

   localparam logic [COEF_W-1:0] ONE_Q14       = 16'h4000;
   localparam logic [COEF_W-1:0] MINUS_ONE_Q14 = 16'hC000;
   localparam logic [COEF_W-1:0] COEF_MAX      = 16'h7FFF;
   localparam logic [COEF_W-1:0] COEF_MIN      = 16'h8000;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   // index 0 is x, 1 is y, 2 is z
   typedef struct packed {
      coord_type [2:0] hi;
      coord_type [2:0] lo;
   } box_type;

   typedef enum int {PLANES_CUBE, PLANES_RANDOM, PLANES_EXTREME} plane_mix_type;
   // who leaves gaps: receiver heavy, then sender heavy, then nobody
   typedef enum int {GAPS_RX_HEAVY, GAPS_TX_HEAVY, GAPS_NONE} gap_mode_type;

   // Scoreboard: mirrors the plane registers and queues the expected verdicts.
   class verdict_scoreboard;
      logic [PLANE_W-1:0]   planes [PLANE_COUNT];
      logic [VERDICT_W-1:0] verdict_q [$];
      int                   errors;

      function new();
         foreach (planes[p]) planes[p] = '0;
         errors = 0;
      endfunction

      function void set_plane(int idx, logic [PLANE_W-1:0] value);
         if (idx < PLANE_COUNT) planes[idx] = value;
      endfunction

      function int pending();
         return verdict_q.size();
      endfunction

      // exact plane test on all eight corners; zero is not in front
      function logic [VERDICT_W-1:0] classify(box_type b);
         longint nx, ny, nz, off, x, y, z;
         int     front, full_planes;
         bit     outside;
         full_planes = 0;
         outside     = 1'b0;
         for (int p = 0; p < PLANE_COUNT; p++) begin
            nx  = longint'($signed(planes[p][COEF_W-1:0]));
            ny  = longint'($signed(planes[p][2*COEF_W-1:COEF_W]));
            nz  = longint'($signed(planes[p][3*COEF_W-1:2*COEF_W]));
            off = longint'($signed(planes[p][4*COEF_W-1:3*COEF_W])) <<< FRAC_BITS;
            front = 0;
            for (int k = 0; k < CORNER_COUNT; k++) begin
               x = ((k & 1) != 0) ? longint'($signed(b.hi[0])) : longint'($signed(b.lo[0]));
               y = ((k & 2) != 0) ? longint'($signed(b.hi[1])) : longint'($signed(b.lo[1]));
               z = ((k & 4) != 0) ? longint'($signed(b.hi[2])) : longint'($signed(b.lo[2]));
               if (nx * x + ny * y + nz * z + off > 0) front++;
            end
            if (front == 0) outside = 1'b1;
            if (front == CORNER_COUNT) full_planes++;
         end
         if (outside) return VERDICT_OUTSIDE;
         if (full_planes == PLANE_COUNT) return VERDICT_INSIDE;
         return VERDICT_PARTIAL;
      endfunction

      function void note_box(box_type b);
         verdict_q.push_back(classify(b));
      endfunction

      task report(string what);
         $display("%0t: %s", $time, what);
         errors++;
      endtask

      task check(logic [VERDICT_W-1:0] got);
         logic [VERDICT_W-1:0] want;
         if (verdict_q.size() == 0) begin
            report($sformatf("verdict %0d with no box outstanding", got));
         end else begin
            want = verdict_q.pop_front();
            if (got !== want) report($sformatf("verdict %0d, want %0d", got, want));
         end
      endtask
   endclass

   logic         clock        = 1'b0;
   logic         reset        = 1'b1;
   logic         req_valid    = 1'b0;
   logic         req_ready;
   coord_type    req_box_lo_x = '0;
   coord_type    req_box_lo_y = '0;
   coord_type    req_box_lo_z = '0;
   coord_type    req_box_hi_x = '0;
   coord_type    req_box_hi_y = '0;
   coord_type    req_box_hi_z = '0;
   logic         rsp_valid;
   logic         rsp_ready    = 1'b0;
   logic [VERDICT_W-1:0]   rsp_verdict;
   logic         csr_write    = 1'b0;
   logic [PLANE_IDX_W-1:0] csr_index = '0;
   logic [PLANE_W-1:0]     csr_data  = '0;

   verdict_scoreboard verdicts;
   logic [PLANE_W-1:0] plane_set [PLANE_COUNT];   // next plane set to load
   gap_mode_type gap_mode   = GAPS_RX_HEAVY;
   int        hold_requests = 0;                  // bumped by the stimulus
   int        holds_served  = 0;
   int        hold_left     = 0;

   aabb_frustum_classify DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_box_lo_x (req_box_lo_x),
      .req_box_lo_y (req_box_lo_y),
      .req_box_lo_z (req_box_lo_z),
      .req_box_hi_x (req_box_hi_x),
      .req_box_hi_y (req_box_hi_y),
      .req_box_hi_z (req_box_hi_z),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_verdict  (rsp_verdict),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // percentage of cycles in which a side leaves a gap
   function automatic int idle_percent(gap_mode_type mode, bit for_sender);
      case (mode)
         GAPS_RX_HEAVY: return for_sender ? 32 : 57;
         GAPS_TX_HEAVY: return for_sender ? 57 : 32;
         default:       return 0;
      endcase
   endfunction

   function automatic logic [COEF_W-1:0] pick_extreme16();
      case ($urandom_range(5))
         0:       return COEF_MIN;
         1:       return COEF_MAX;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         4:       return 16'h0001;
         default: return COEF_W'($urandom);
      endcase
   endfunction

   function automatic logic [PLANE_W-1:0] pack_plane(logic [COEF_W-1:0] nx, logic [COEF_W-1:0] ny,
                                                     logic [COEF_W-1:0] nz, logic [COEF_W-1:0] off);
      return {off, nz, ny, nx};
   endfunction

   function automatic box_type make_box(int lx, int ly, int lz, int hx, int hy, int hz);
      box_type b;
      b.lo[0] = coord_type'(lx);
      b.lo[1] = coord_type'(ly);
      b.lo[2] = coord_type'(lz);
      b.hi[0] = coord_type'(hx);
      b.hi[1] = coord_type'(hy);
      b.hi[2] = coord_type'(hz);
      return b;
   endfunction

   // Mostly boxes of random size around the origin, so that all three
   // verdicts come up; the rest are full-range, point and extreme corners.
   // lo and hi are drawn independently, so swapped corners are common.
   function automatic box_type random_box(int scale);
      box_type b;
      int   pick, centre, half;
      pick = $urandom_range(99);
      for (int a = 0; a < 3; a++) begin
         if (pick < 60) begin
            centre  = int'($urandom_range(2 * scale)) - scale;
            half    = $urandom_range(scale / 4);
            b.lo[a] = coord_type'(centre + int'($urandom_range(2 * half)) - half);
            b.hi[a] = coord_type'(centre + int'($urandom_range(2 * half)) - half);
         end else if (pick < 80) begin
            b.lo[a] = coord_type'($urandom);
            b.hi[a] = coord_type'($urandom);
         end else if (pick < 90) begin
            b.lo[a] = coord_type'($urandom);
            b.hi[a] = b.lo[a];
         end else begin
            b.lo[a] = coord_type'(pick_extreme16());
            b.hi[a] = coord_type'(pick_extreme16());
         end
      end
      return b;
   endfunction

   // Cube sets: plane p faces along axis p/2, sign by p%2, with a slight tilt.
   function automatic logic [PLANE_W-1:0] random_plane(plane_mix_type mix, int p);
      logic [COEF_W-1:0] n [3];
      int axis;
      case (mix)
         PLANES_RANDOM:  return {$urandom, $urandom};
         PLANES_EXTREME: return pack_plane(pick_extreme16(), pick_extreme16(),
                                           pick_extreme16(), pick_extreme16());
         default: begin
            axis = p / 2;
            for (int a = 0; a < 3; a++) n[a] = COEF_W'($urandom_range(512)) - COEF_W'(256);
            n[axis] = COEF_W'($urandom_range(16'h7FFF, 16'h2000));
            if (p % 2 != 0) n[axis] = -n[axis];
            return pack_plane(n[0], n[1], n[2], COEF_W'($urandom_range(8000, 1)));
         end
      endcase
   endfunction

   // Offer one box and wait for its transfer. Valid is left high on return
   // so a back-to-back box never lowers and re-raises it in one step.
   task automatic send_box(input box_type b);
      while ($urandom_range(99) < idle_percent(gap_mode, 1'b1)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_box_lo_x <= b.lo[0];
      req_box_lo_y <= b.lo[1];
      req_box_lo_z <= b.lo[2];
      req_box_hi_x <= b.hi[0];
      req_box_hi_y <= b.hi[1];
      req_box_hi_z <= b.hi[2];
      do @(posedge clock); while (!req_ready);
      verdicts.note_box(b);
   endtask

   // stop offering and wait until every verdict is back
   task automatic drain_verdicts();
      req_valid <= 1'b0;
      do @(posedge clock); while (verdicts.pending() != 0);
   endtask

   // Load plane_set into all six registers back to back; optionally one
   // extra write to an index past the last plane, which must change nothing.
   task automatic write_planes(input bit add_unused);
      for (int p = 0; p < PLANE_COUNT; p++) begin
         csr_write <= 1'b1;
         csr_index <= PLANE_IDX_W'(p);
         csr_data  <= plane_set[p];
         verdicts.set_plane(p, plane_set[p]);
         @(posedge clock);
      end
      if (add_unused) begin
         csr_index <= PLANE_IDX_W'($urandom_range(2 ** PLANE_IDX_W - 1, PLANE_COUNT));
         csr_data  <= {$urandom, $urandom};
         @(posedge clock);
      end
      csr_write <= 1'b0;
   endtask

   // Receiver: checks each verdict transfer (values sampled before the edge)
   // and decides rsp_ready for the next cycle. A long hold-off is counted here.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) verdicts.check(rsp_verdict);
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (holds_served != hold_requests) begin
            holds_served <= holds_served + 1;
            hold_left    <= LONG_HOLD;
            rsp_ready    <= 1'b0;
         end else begin
            rsp_ready <= $urandom_range(99) >= idle_percent(gap_mode, 1'b0);
         end
      end
   end

   initial begin
      int sent;
      plane_mix_type mix;
      verdicts = new();
      sent = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // planes still at reset: everything is outside
      send_box(make_box(0, 0, 0, 0, 0, 0));
      send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
      send_box(random_box(1000));
      drain_verdicts();

      // axis-aligned cube, faces at +/-1000
      plane_set[NEAR_IDX]   = pack_plane(16'h0000, 16'h0000, ONE_Q14, 16'd1000);
      plane_set[FAR_IDX]    = pack_plane(16'h0000, 16'h0000, MINUS_ONE_Q14, 16'd1000);
      plane_set[LEFT_IDX]   = pack_plane(ONE_Q14, 16'h0000, 16'h0000, 16'd1000);
      plane_set[RIGHT_IDX]  = pack_plane(MINUS_ONE_Q14, 16'h0000, 16'h0000, 16'd1000);
      plane_set[BOTTOM_IDX] = pack_plane(16'h0000, ONE_Q14, 16'h0000, 16'd1000);
      plane_set[TOP_IDX]    = pack_plane(16'h0000, MINUS_ONE_Q14, 16'h0000, 16'd1000);
      write_planes(1'b0);
      send_box(make_box(-10, -10, -10, 10, 10, 10));          // inside
      send_box(make_box(10, 10, 10, -10, -10, -10));          // swapped corners
      send_box(make_box(0, 0, 0, 0, 0, 0));                   // single point
      send_box(make_box(-999, -999, -999, 999, 999, 999));    // just inside
      send_box(make_box(-1000, -10, -10, 999, 10, 10));       // one face touching
      send_box(make_box(-1000, -1000, -1000, -1000, -1000, -1000)); // point on a face
      send_box(make_box(-1001, 0, 0, -1000, 0, 0));           // behind, touching
      send_box(make_box(-1001, 0, 0, -999, 0, 0));            // straddling
      send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
      send_box(make_box(2000, 2000, 2000, 3000, 3000, 3000)); // well out
      send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
      send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
      send_box(make_box(500, 0, 0, 1500, 0, 0));
      send_box(make_box(-32768, 0, 0, 32767, 0, 0));
      drain_verdicts();

      // extreme coefficients everywhere: widest sums
      foreach (plane_set[p]) plane_set[p] = pack_plane(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX);
      write_planes(1'b1);
      send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
      send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
      send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
      drain_verdicts();

      // random part: a fresh plane set per phase, gaps regime by progress
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         mix = plane_mix_type'(phase % 3);
         foreach (plane_set[p]) plane_set[p] = random_plane(mix, p);
         write_planes(1'($urandom_range(1)));
         if (phase == 2) hold_requests <= hold_requests + 1;   // block fills and stalls
         for (int n = 0; n < BOXES_PER_PHASE; n++) begin
            if (sent < RANDOM_PHASES * BOXES_PER_PHASE / 3) gap_mode <= GAPS_RX_HEAVY;
            else if (sent < 2 * RANDOM_PHASES * BOXES_PER_PHASE / 3) gap_mode <= GAPS_TX_HEAVY;
            else gap_mode <= GAPS_NONE;
            if (phase == 5 && n == 60) drain_verdicts();        // sender pause mid-phase
            send_box(random_box($urandom_range(20000, 8)));
            sent++;
         end
         drain_verdicts();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (verdicts.errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #20_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: aabb_frustum_classify.f
design/afc_pkg.sv
design/afc_mac.sv
design/aabb_frustum_classify.sv
sim/testbench.sv
